@@ design/sjag_pkg.sv @@
// Shared constants and tables for the sine joint angle generator.
package sjag_pkg;

    localparam int PHASE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int TIME_W    = 32;
    localparam int FREQ_W    = 24;
    localparam int AMP_W     = 20;
    localparam int ANGLE_W   = 22;
    localparam int VEL_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    // Datapath widths: CORDIC x/y in Q30 with headroom, angle accumulator in turns * 2^32,
    // freq*amp in Q16, and the intermediate velocity term in Q16.
    localparam int XW  = 33;
    localparam int ZW  = 32;
    localparam int FAW = 30;
    localparam int TW  = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 2'd2;

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [32:0]   TWO_PI_Q29      = 33'sd3373259426;

    // round(2^32 * atan(2^-i) / (2*pi)) for each micro-rotation.
    localparam logic [29:0] ATAN_TURNS [ATAN_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

endpackage

@@ design/sine_joint_angle_generator_top.sv @@
// Pipelined sinusoidal joint trajectory generator: angle and angular velocity per time stamp.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+----------------------------------------------
//  config   | cfg_we                | cfg_index, cfg_data
//  input    | in_valid / in_ready   | time_stamp
//  output   | out_valid / out_ready | joint_angle, joint_velocity
//
// One beat enters per cycle while in_ready is high; a beat passes the phase stage, one CORDIC
// micro-rotation per stage, the fold, multiply, round, velocity multiply and output stages.
// Reset clears the configuration registers and all stage valid bits.
// When the output stalls, each stage holds only if every stage after it is full, so
// bubbles close up and in_ready drops only when the whole pipeline is occupied.
module sine_joint_angle_generator_top #(
    parameter int PHASE_BITS    = sjag_pkg::PHASE_BITS_DEF,
    parameter int CORDIC_STAGES = sjag_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sjag_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sjag_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sjag_pkg::TIME_W-1:0]          time_stamp,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sjag_pkg::ANGLE_W-1:0]  joint_angle,
    output logic signed [sjag_pkg::VEL_W-1:0]    joint_velocity
);

    localparam int XW  = sjag_pkg::XW;
    localparam int ZW  = sjag_pkg::ZW;
    localparam int FAW = sjag_pkg::FAW;
    localparam int TW  = sjag_pkg::TW;
    localparam int AMP_W = sjag_pkg::AMP_W;
    localparam int FREQ_W = sjag_pkg::FREQ_W;
    localparam int ANGLE_W = sjag_pkg::ANGLE_W;
    localparam int VEL_W = sjag_pkg::VEL_W;

    localparam int ASW = AMP_W + XW;          // amp * sin
    localparam int FCW = FAW + XW;            // fa * cos
    localparam int VPW = TW + 33;             // t1 * 2pi
    localparam int FPW = FREQ_W + AMP_W + 1;  // freq * amp
    localparam int AGW = ANGLE_W + 2;         // angle before clipping
    localparam int VGW = VEL_W + 2;           // velocity before clipping

    // Stage map.
    localparam int ST_PHASE = 0;
    localparam int ST_FOLD  = CORDIC_STAGES + 1;
    localparam int ST_MUL   = CORDIC_STAGES + 2;
    localparam int ST_RND   = CORDIC_STAGES + 3;
    localparam int ST_VMUL  = CORDIC_STAGES + 4;
    localparam int ST_OUT   = CORDIC_STAGES + 5;
    localparam int NS       = CORDIC_STAGES + 6;

    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    localparam logic signed [ASW-1:0] AS_HALF = ASW'(64'sd1 << 29);
    localparam logic signed [FCW-1:0] FC_HALF = FCW'(64'sd1 << 29);
    localparam logic signed [VPW-1:0] VP_HALF = VPW'(64'sd1 << 28);
    localparam logic signed [FPW-1:0] FP_HALF = FPW'(64'sd1 << 15);
    localparam logic signed [AGW-1:0] ANG_MAX = AGW'((64'sd1 << (ANGLE_W - 1)) - 1);
    localparam logic signed [AGW-1:0] ANG_MIN = -AGW'(64'sd1 << (ANGLE_W - 1));
    localparam logic signed [VGW-1:0] VEL_MAX = VGW'((64'sd1 << (VEL_W - 1)) - 1);
    localparam logic signed [VGW-1:0] VEL_MIN = -VGW'(64'sd1 << (VEL_W - 1));

    // Configuration registers.
    logic [FREQ_W-1:0]       freq_reg;
    logic signed [AMP_W-1:0] amp_reg;
    logic signed [AMP_W-1:0] off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
            amp_reg  <= '0;
            off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sjag_pkg::CFG_FREQUENCY:    freq_reg <= cfg_data[FREQ_W-1:0];
                sjag_pkg::CFG_AMPLITUDE:    amp_reg  <= cfg_data[AMP_W-1:0];
                sjag_pkg::CFG_ANGLE_OFFSET: off_reg  <= cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // freq*amp depends on configuration only; it is registered in fa_prod_reg and then fa_reg,
    // long before any beat reaches the multiplier stage.
    logic signed [FPW-1:0] fa_prod_reg;
    logic signed [FAW-1:0] fa_reg;

    always_ff @(posedge clk)
    begin
        fa_prod_reg <= FPW'($signed({1'b0, freq_reg})) * FPW'(amp_reg);
        fa_reg      <= FAW'((fa_prod_reg + FP_HALF) >>> 16);
    end

    // Stage valid bits and per-stage advance enables.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            en[k] = out_ready || (|((~v_reg) >> k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign in_ready  = en[ST_PHASE];
    assign out_valid = v_reg[ST_OUT];

    // Phase stage: fractional turns of freq * time.
    logic [31:0] phase_reg;
    logic [31:0] phase_next;

    assign phase_next = ({8'b0, freq_reg} * time_stamp) & PHASE_MASK;

    always_ff @(posedge clk)
    begin
        if (en[ST_PHASE])
        begin
            phase_reg <= phase_next;
        end
    end

    // CORDIC rotation stages, one micro-rotation per register stage.
    logic signed [XW-1:0] cx_reg [CORDIC_STAGES];
    logic signed [XW-1:0] cy_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] cz_reg [CORDIC_STAGES];
    logic [1:0]           cq_reg [CORDIC_STAGES];

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(sjag_pkg::ATAN_TURNS[gi]));

        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [1:0]           q_in;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (gi == 0)
        begin : g_first
            assign x_in = sjag_pkg::CORDIC_GAIN_Q30;
            assign y_in = '0;
            assign z_in = $signed({2'b00, phase_reg[29:0]});
            assign q_in = phase_reg[31:30];
        end
        else
        begin : g_rest
            assign x_in = cx_reg[gi-1];
            assign y_in = cy_reg[gi-1];
            assign z_in = cz_reg[gi-1];
            assign q_in = cq_reg[gi-1];
        end

        always_comb
        begin
            if (!z_in[ZW-1])
            begin
                x_next = x_in - (y_in >>> gi);
                y_next = y_in + (x_in >>> gi);
                z_next = z_in - ATAN;
            end
            else
            begin
                x_next = x_in + (y_in >>> gi);
                y_next = y_in - (x_in >>> gi);
                z_next = z_in + ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[gi+1])
            begin
                cx_reg[gi] <= x_next;
                cy_reg[gi] <= y_next;
                cz_reg[gi] <= z_next;
                cq_reg[gi] <= q_in;
            end
        end
    end

    // Quadrant fold back to full-circle sine and cosine.
    logic signed [XW-1:0] sin_reg;
    logic signed [XW-1:0] cos_reg;
    logic signed [XW-1:0] sin_next;
    logic signed [XW-1:0] cos_next;
    logic signed [XW-1:0] fx;
    logic signed [XW-1:0] fy;

    assign fx = cx_reg[CORDIC_STAGES-1];
    assign fy = cy_reg[CORDIC_STAGES-1];

    always_comb
    begin
        case (cq_reg[CORDIC_STAGES-1])
            2'd0:
            begin
                sin_next = fy;
                cos_next = fx;
            end
            2'd1:
            begin
                sin_next = fx;
                cos_next = -fy;
            end
            2'd2:
            begin
                sin_next = -fy;
                cos_next = -fx;
            end
            default:
            begin
                sin_next = -fx;
                cos_next = fy;
            end
        endcase
    end

    // Fold, multiply, round, velocity multiply and output registers.
    logic signed [ASW-1:0]     as_prod_reg;
    logic signed [FCW-1:0]     fc_prod_reg;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic signed [ANGLE_W-1:0] ang_d_reg;
    logic signed [TW-1:0]      t1_reg;
    logic signed [VPW-1:0]     vprod_reg;
    logic signed [ANGLE_W-1:0] ang_out_reg;
    logic signed [VEL_W-1:0]   vel_out_reg;

    logic signed [ASW-1:0]     as_rnd;
    logic signed [FCW-1:0]     fc_rnd;
    logic signed [AGW-1:0]     ang_sum;
    logic signed [ANGLE_W-1:0] ang_next;
    logic signed [TW-1:0]      t1_next;
    logic signed [VPW-1:0]     vp_rnd;
    logic signed [VGW-1:0]     vel_sum;
    logic signed [VEL_W-1:0]   vel_next;

    always_comb
    begin
        as_rnd  = as_prod_reg + AS_HALF;
        fc_rnd  = fc_prod_reg + FC_HALF;
        ang_sum = AGW'(as_rnd >>> 30) + AGW'(off_reg);
        if (ang_sum > ANG_MAX)
        begin
            ang_next = ANGLE_W'(ANG_MAX);
        end
        else if (ang_sum < ANG_MIN)
        begin
            ang_next = ANGLE_W'(ANG_MIN);
        end
        else
        begin
            ang_next = ANGLE_W'(ang_sum);
        end
        t1_next = TW'(fc_rnd >>> 30);

        vp_rnd  = vprod_reg + VP_HALF;
        vel_sum = VGW'(vp_rnd >>> 29);
        if (vel_sum > VEL_MAX)
        begin
            vel_next = VEL_W'(VEL_MAX);
        end
        else if (vel_sum < VEL_MIN)
        begin
            vel_next = VEL_W'(VEL_MIN);
        end
        else
        begin
            vel_next = VEL_W'(vel_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_FOLD])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
        if (en[ST_MUL])
        begin
            as_prod_reg <= ASW'(amp_reg) * ASW'(sin_reg);
            fc_prod_reg <= FCW'(fa_reg) * FCW'(cos_reg);
        end
        if (en[ST_RND])
        begin
            ang_reg <= ang_next;
            t1_reg  <= t1_next;
        end
        if (en[ST_VMUL])
        begin
            ang_d_reg <= ang_reg;
            vprod_reg <= VPW'(t1_reg) * VPW'(sjag_pkg::TWO_PI_Q29);
        end
        if (en[ST_OUT])
        begin
            ang_out_reg <= ang_d_reg;
            vel_out_reg <= vel_next;
        end
    end

    assign joint_angle    = ang_out_reg;
    assign joint_velocity = vel_out_reg;

`ifndef SYNTHESIS
    // An accepted beat always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[ST_PHASE])
    else $error("accepted beat missing from phase stage");

    // A full stage just behind a stalled output must hold its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && v_reg[ST_VMUL] |=> v_reg[ST_VMUL] && out_valid)
    else $error("beat dropped behind stalled output");

    // Beats in flight change only by accepted inputs and delivered results.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) == $past($countones(v_reg))
            + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready))))
    else $error("pipeline beat count out of balance");
`endif

endmodule
